[rtl/bol_pkg.sv]
package bol_pkg;

  localparam int unsigned BOL_CAPACITY = 64;

  localparam int unsigned BOL_TYPE_W   = 2;
  localparam int unsigned BOL_DATA_W   = 32;
  localparam int unsigned BOL_POS_W    = 7;
  localparam int unsigned BOL_STATUS_W = 2;
  localparam int unsigned BOL_COUNT_W  = 7;

  // request kinds
  localparam logic [BOL_TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [BOL_TYPE_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [BOL_TYPE_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [BOL_TYPE_W-1:0] REQ_DUMP   = 2'd3;

  // result status codes
  localparam logic [BOL_STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [BOL_STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [BOL_STATUS_W-1:0] STS_RANGE = 2'd2;
  localparam logic [BOL_STATUS_W-1:0] STS_EMPTY = 2'd3;

  // control from the sequencer to the ring store
  typedef struct packed {
    logic we;          // write at logical position
    logic push_front;  // move head back by one and write there
    logic re;          // read at logical position
  } bol_ctl_t;

endpackage

[rtl/bol_if.sv]
interface bol_req_if;
  import bol_pkg::*;

  logic                         valid;
  logic                         ready;
  logic        [BOL_TYPE_W-1:0] req_type;
  logic signed [BOL_DATA_W-1:0] new_value;
  logic        [BOL_POS_W-1:0]  position;

  modport source (output valid, output req_type, output new_value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input new_value, input position,
                  output ready);
endinterface

interface bol_rsp_if;
  import bol_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [BOL_DATA_W-1:0]   out_value;
  logic                           is_last;
  logic        [BOL_STATUS_W-1:0] status;
  logic        [BOL_COUNT_W-1:0]  entry_count;

  modport source (output valid, output out_value, output is_last, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input out_value, input is_last, input status,
                  input entry_count, output ready);
endinterface

[rtl/bol_ring.sv]
module bol_ring #(
  parameter int unsigned CAPACITY = bol_pkg::BOL_CAPACITY,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bol_pkg::bol_ctl_t                    ctl_i,
  input  logic [AW-1:0]                        wpos_i,
  input  logic signed [bol_pkg::BOL_DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]                        rpos_i,
  output logic signed [bol_pkg::BOL_DATA_W-1:0] rdata_o
);
  import bol_pkg::*;

  localparam logic [AW:0] CapW = (AW + 1)'(CAPACITY);

  logic signed [BOL_DATA_W-1:0] mem_q [CAPACITY];
  logic signed [BOL_DATA_W-1:0] rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] waddr, raddr;

  // logical position to physical slot, head + pos wraps at most once
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                            input logic [AW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= CapW) sum = sum - CapW;
    return sum[AW-1:0];
  endfunction

  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
  assign head_d   = ctl_i.push_front ? head_dec : head_q;
  assign waddr    = ctl_i.push_front ? head_dec : wrap_add(head_q, wpos_i);
  assign raddr    = wrap_add(head_q, rpos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we || ctl_i.push_front) begin
      mem_q[waddr] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bounded_ordered_list.sv]
// channel | dir | handshake       | word
// req_i   | in  | valid / ready   | req_type, new_value, position
// rsp_o   | out | valid / ready   | out_value, is_last, status, entry_count
//
// insert, append and rejected requests load their result straight into the output register.
// delete at position p copies the tail forward one entry per cycle through the single
// read and write port of the ring.
// dump sends one value per cycle while the output is not stalled.
// reset clears the count and the head pointer; list contents are not cleared.
// a stalled output holds the sequencer; no new request is taken until it moves.
module bounded_ordered_list #(
  parameter int unsigned CAPACITY = bol_pkg::BOL_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bol_req_if.sink   req_i,
  bol_rsp_if.source rsp_o
);
  import bol_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_DUMP  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic          pend_q, pend_d;
  logic          last_q, last_d;

  logic                           out_valid_q, out_valid_d;
  logic signed [BOL_DATA_W-1:0]   out_value_q, out_value_d;
  logic                           is_last_q, is_last_d;
  logic        [BOL_STATUS_W-1:0] status_q, status_d;
  logic        [BOL_COUNT_W-1:0]  ecount_q, ecount_d;
  logic                           out_load;

  bol_ctl_t                     ctl;
  logic [AW-1:0]                wpos, rpos;
  logic signed [BOL_DATA_W-1:0] wdata, rdata;

  logic out_free, in_ready, acc, full, more, move;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign in_ready = (state_q == ST_IDLE) && out_free;
  assign acc      = req_i.valid && in_ready;
  assign full     = (count_q == CW'(CAPACITY));
  assign more     = (rd_idx_q < count_q);
  assign move     = pend_q && out_free;

  assign req_i.ready = in_ready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    pend_d      = pend_q;
    last_d      = last_q;
    ctl         = '0;
    wpos        = count_q[AW-1:0];
    wdata       = req_i.new_value;
    rpos        = rd_idx_q[AW-1:0];
    out_load    = 1'b0;
    out_value_d = '0;
    is_last_d   = 1'b1;
    status_d    = STS_OK;
    ecount_d    = BOL_COUNT_W'(count_q);

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_i.req_type)
            REQ_INSERT, REQ_APPEND: begin
              out_load = 1'b1;
              if (full) begin
                status_d = STS_FULL;
              end else begin
                ctl.push_front = (req_i.req_type == REQ_INSERT);
                ctl.we         = (req_i.req_type == REQ_APPEND);
                count_d        = count_q + 1'b1;
                ecount_d       = BOL_COUNT_W'(count_d);
              end
            end
            REQ_DELETE: begin
              if (req_i.position < BOL_POS_W'(count_q)) begin
                wr_idx_d = req_i.position[CW-1:0];
                rd_idx_d = req_i.position[CW-1:0] + 1'b1;
                pend_d   = 1'b0;
                state_d  = ST_SHIFT;
              end else begin
                out_load = 1'b1;
                status_d = STS_RANGE;
              end
            end
            default: begin
              if (count_q == '0) begin
                out_load = 1'b1;
                status_d = STS_EMPTY;
              end else begin
                rd_idx_d = '0;
                pend_d   = 1'b0;
                state_d  = ST_DUMP;
              end
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // read runs one entry ahead of the write, never the same slot
        ctl.re = more;
        if (more) rd_idx_d = rd_idx_q + 1'b1;
        pend_d = more;
        if (pend_q) begin
          ctl.we   = 1'b1;
          wpos     = wr_idx_q[AW-1:0];
          wdata    = rdata;
          wr_idx_d = wr_idx_q + 1'b1;
        end
        if (!pend_q && !more && out_free) begin
          count_d  = count_q - 1'b1;
          out_load = 1'b1;
          ecount_d = BOL_COUNT_W'(count_d);
          state_d  = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // refill the read register when it is empty or when its word leaves this cycle
        ctl.re = more && (!pend_q || move);
        if (ctl.re) begin
          rd_idx_d = rd_idx_q + 1'b1;
          last_d   = (CW'(rd_idx_q + 1'b1) == count_q);
          pend_d   = 1'b1;
        end else if (move) begin
          pend_d = 1'b0;
        end
        if (move) begin
          out_load    = 1'b1;
          out_value_d = rdata;
          is_last_d   = last_q;
          if (last_q) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  bol_ring #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .wpos_i  (wpos),
    .wdata_i (wdata),
    .rpos_i  (rpos),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    last_q   <= last_d;
    if (out_load) begin
      out_value_q <= out_value_d;
      is_last_q   <= is_last_d;
      status_q    <= status_d;
      ecount_q    <= ecount_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_value   = out_value_q;
  assign rsp_o.is_last     = is_last_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = ecount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q != ST_IDLE))
    else $error("read in flight while idle");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && full && (req_i.req_type == REQ_INSERT || req_i.req_type == REQ_APPEND))
    |=> (rsp_o.valid && rsp_o.status == STS_FULL && $stable(count_q)))
    else $error("insert into full list not dropped");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && move && last_q) |=> (state_q == ST_IDLE && rsp_o.is_last))
    else $error("dump did not end on last word");

endmodule

[dv/bounded_ordered_list_tb.sv]
module bounded_ordered_list_tb;
  import bol_pkg::*;

  localparam int unsigned CAPACITY     = BOL_CAPACITY;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 8;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned NUM_DIRECTED = 25;

  typedef struct packed {
    logic signed [BOL_DATA_W-1:0]   value;
    logic                           last;
    logic        [BOL_STATUS_W-1:0] status;
    logic        [BOL_COUNT_W-1:0]  count;
  } list_word_t;

  typedef struct packed {
    logic        [BOL_TYPE_W-1:0]   kind;
    logic signed [BOL_DATA_W-1:0]   val;
    logic        [BOL_POS_W-1:0]    pos;
    logic                           typed;
    logic        [BOL_STATUS_W-1:0] status;
    logic        [BOL_COUNT_W-1:0]  count;
  } list_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  bol_req_if req_if ();
  bol_rsp_if rsp_if ();

  bounded_ordered_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // shadow of the list contents, front at index 0
  logic signed [BOL_DATA_W-1:0] list_vals[$];
  list_word_t                   step_words[$];
  list_word_t                   pending_words[$];
  list_row_t                    dir_rows[NUM_DIRECTED];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_asks;
  int unsigned fail_count;
  int unsigned words_checked;
  int unsigned full_drops;
  int unsigned range_rejects;
  int unsigned kind_seen[4];
  int unsigned cycle_cnt;

  // works out the words one request produces and updates the shadow list
  function automatic void model_request(input logic [BOL_TYPE_W-1:0] kind,
                                        input logic signed [BOL_DATA_W-1:0] val,
                                        input logic [BOL_POS_W-1:0] pos);
    list_word_t  w;
    int unsigned n;
    step_words.delete();
    w.value  = '0;
    w.last   = 1'b1;
    w.status = STS_OK;
    w.count  = '0;
    n = list_vals.size();
    kind_seen[kind]++;
    case (kind)
      REQ_INSERT, REQ_APPEND: begin
        if (n >= CAPACITY) begin
          w.status = STS_FULL;
          full_drops++;
        end else if (kind == REQ_INSERT) begin
          list_vals.push_front(val);
        end else begin
          list_vals.push_back(val);
        end
        w.count = BOL_COUNT_W'(list_vals.size());
        step_words.push_back(w);
      end
      REQ_DELETE: begin
        if (pos >= n) begin
          w.status = STS_RANGE;
          range_rejects++;
        end else begin
          list_vals.delete(pos);
        end
        w.count = BOL_COUNT_W'(list_vals.size());
        step_words.push_back(w);
      end
      default: begin
        if (n == 0) begin
          w.status = STS_EMPTY;
          step_words.push_back(w);
        end else begin
          for (int i = 0; i < n; i++) begin
            w.value = list_vals[i];
            w.last  = (i == n - 1);
            w.count = BOL_COUNT_W'(n);
            step_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  function automatic logic [BOL_POS_W-1:0] pick_position();
    if (list_vals.size() > 0 && $urandom_range(0, 99) < 80)
      return BOL_POS_W'($urandom_range(0, list_vals.size() - 1));
    return BOL_POS_W'($urandom_range(0, 2**BOL_POS_W - 1));
  endfunction

  task automatic send_word(input list_row_t row);
    list_word_t fixed;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= row.kind;
    req_if.new_value <= row.val;
    req_if.position  <= row.pos;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    model_request(row.kind, row.val, row.pos);
    if (row.typed) begin
      // status words read straight off the table
      fixed.value  = '0;
      fixed.last   = 1'b1;
      fixed.status = row.status;
      fixed.count  = row.count;
      pending_words.push_back(fixed);
    end else begin
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    end
  endtask

  task automatic send_random(input logic [BOL_TYPE_W-1:0] kind);
    list_row_t row;
    row.kind   = kind;
    row.val    = $urandom;
    row.pos    = pick_position();
    row.typed  = 1'b0;
    row.status = STS_OK;
    row.count  = '0;
    send_word(row);
  endtask

  // result side: check and random ready, with one long hold-off on request
  initial begin
    int unsigned hold_done;
    int unsigned hold_left;
    list_word_t  exp_w;
    hold_done = 0;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_words.size() == 0) begin
          fail_count++;
          $display("%0t: word with nothing expected, value %0d last %0b status %0d count %0d",
                   $time, rsp_if.out_value, rsp_if.is_last, rsp_if.status,
                   rsp_if.entry_count);
        end else begin
          exp_w = pending_words.pop_front();
          words_checked++;
          if (rsp_if.out_value !== exp_w.value) begin
            fail_count++;
            $display("%0t: out_value expected %0d actual %0d",
                     $time, exp_w.value, rsp_if.out_value);
          end
          if (rsp_if.is_last !== exp_w.last) begin
            fail_count++;
            $display("%0t: is_last expected %0b actual %0b", $time, exp_w.last, rsp_if.is_last);
          end
          if (rsp_if.status !== exp_w.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, exp_w.status, rsp_if.status);
          end
          if (rsp_if.entry_count !== exp_w.count) begin
            fail_count++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp_w.count, rsp_if.entry_count);
          end
        end
      end
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned full_hits;
    int unsigned roll;
    logic [BOL_TYPE_W-1:0] kind;

    dir_rows = '{
      '{REQ_DUMP,   32'sh0000_0000, 7'd0,   1'b1, STS_EMPTY, 7'd0},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_RANGE, 7'd0},
      '{REQ_DELETE, 32'sh0000_0000, 7'd127, 1'b1, STS_RANGE, 7'd0},
      '{REQ_INSERT, 32'sh7fff_ffff, 7'd0,   1'b1, STS_OK,    7'd1},
      '{REQ_APPEND, 32'sh8000_0000, 7'd0,   1'b1, STS_OK,    7'd2},
      '{REQ_INSERT, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd3},
      '{REQ_APPEND, 32'shffff_ffff, 7'd0,   1'b1, STS_OK,    7'd4},
      '{REQ_INSERT, 32'sh5555_5555, 7'd0,   1'b1, STS_OK,    7'd5},
      '{REQ_APPEND, 32'shaaaa_aaaa, 7'd0,   1'b1, STS_OK,    7'd6},
      '{REQ_DUMP,   32'sh0000_0000, 7'd0,   1'b0, STS_OK,    7'd0},
      '{REQ_DELETE, 32'sh0000_0000, 7'd6,   1'b1, STS_RANGE, 7'd6},
      '{REQ_DELETE, 32'sh0000_0000, 7'd5,   1'b1, STS_OK,    7'd5},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd4},
      '{REQ_DELETE, 32'sh0000_0000, 7'd1,   1'b1, STS_OK,    7'd3},
      '{REQ_DELETE, 32'shffff_ffff, 7'd127, 1'b1, STS_RANGE, 7'd3},
      '{REQ_DUMP,   32'shffff_ffff, 7'd127, 1'b0, STS_OK,    7'd0},
      '{REQ_INSERT, 32'sh1234_5678, 7'd127, 1'b1, STS_OK,    7'd4},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd3},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd2},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd1},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd0},
      '{REQ_DUMP,   32'sh0000_0000, 7'd0,   1'b1, STS_EMPTY, 7'd0},
      '{REQ_APPEND, 32'sh0000_0001, 7'd0,   1'b1, STS_OK,    7'd1},
      '{REQ_DUMP,   32'sh0000_0000, 7'd0,   1'b0, STS_OK,    7'd0},
      '{REQ_DELETE, 32'sh0000_0000, 7'd0,   1'b1, STS_OK,    7'd0}
    };

    src_idle_pct  = 38;
    snk_idle_pct  = 50;
    hold_asks     = 0;
    fail_count    = 0;
    words_checked = 0;
    full_drops    = 0;
    range_rejects = 0;
    cycle_cnt     = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    full_hits = 0;

    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_INSERT;
    req_if.new_value = '0;
    req_if.position  = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // grow until the list is full, then keep pushing into the full list
    while (full_hits < 6) begin
      roll = $urandom_range(0, 99);
      if (roll < 90) kind = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
      else if (roll < 95) kind = REQ_DELETE;
      else kind = REQ_DUMP;
      if ((kind == REQ_INSERT || kind == REQ_APPEND) && list_vals.size() == CAPACITY)
        full_hits++;
      send_random(kind);
    end
    send_random(REQ_DUMP);

    // mostly shrink, with dumps along the way
    src_idle_pct = 50;
    snk_idle_pct = 38;
    repeat (10) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) kind = REQ_DELETE;
      else if (roll < 75) kind = REQ_DUMP;
      else kind = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
      send_random(kind);
    end

    // full speed, starting with the result side held off so the input backs up
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_asks++;
    repeat (10) send_random(BOL_TYPE_W'($urandom_range(0, 3)));

    req_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("requests: %0d insert, %0d append, %0d delete, %0d dump",
             kind_seen[REQ_INSERT], kind_seen[REQ_APPEND], kind_seen[REQ_DELETE],
             kind_seen[REQ_DUMP]);
    $display("%0d words checked, %0d inserts into a full list, %0d deletes out of range",
             words_checked, full_drops, range_rejects);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bol_pkg.sv
rtl/bol_if.sv
rtl/bol_ring.sv
rtl/bounded_ordered_list.sv
dv/bounded_ordered_list_tb.sv
